// File: hdl/twhm_pkg.sv
// Package for the time window hit merger: field structs, kinds, sizes.
// No dependencies.
package twhm_pkg;

    localparam int MaxHits  = 64;
    localparam int IdxW     = 6;
    localparam int CntW     = 7;

    localparam logic [2:0] KIND_MERGED  = 3'd0;
    localparam logic [2:0] KIND_NEW     = 3'd1;
    localparam logic [2:0] KIND_SKIPPED = 3'd2;
    localparam logic [2:0] KIND_DROPPED = 3'd3;
    localparam logic [2:0] KIND_READOUT = 3'd4;
    localparam logic [2:0] KIND_EMPTY   = 3'd5;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_EOE  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic        [23:0] energy_deposit;
        logic        [31:0] hit_time;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] mom_z;
        logic        [19:0] track_id;
    } t_in_word;

    typedef struct packed {
        logic        [2:0]  record_kind;
        logic        [5:0]  entry_index;
        logic        [23:0] out_energy;
        logic        [31:0] out_time;
        logic signed [23:0] out_pos_x;
        logic signed [23:0] out_pos_y;
        logic signed [23:0] out_pos_z;
        logic signed [31:0] out_mom_x;
        logic signed [31:0] out_mom_y;
        logic signed [31:0] out_mom_z;
        logic        [19:0] out_track;
        logic               last;
    } t_out_word;

    // Hit content without the energy (taken from a step on earlier time).
    typedef struct packed {
        logic        [31:0] tm;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
        logic        [19:0] trk;
    } t_hit_body;

    // Controller to datapath commands
    typedef struct packed {
        logic            load_in;   // capture input word
        logic            do_update; // write hit table for the captured step
        logic            emit_blank;
        logic [2:0]      blank_kind;
        logic            rd_req;    // read entry rd_idx for readout
        logic [IdxW-1:0] rd_idx;
        logic            rd_last;
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic            is_eoe;
        logic            zero_e;
    } t_dp_stat;

endpackage

// File: hdl/twhm_datapath.sv
// Datapath: hit table, per-entry time compare, priority pick, update, output register.
// Depends on twhm_pkg.
module twhm_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_window,
    input  twhm_pkg::t_in_word  i_word,
    input  twhm_pkg::t_ctl_cmd  i_cmd,
    output twhm_pkg::t_dp_stat  o_stat,
    output logic [twhm_pkg::CntW-1:0] o_count,
    output logic                o_strobe,
    output twhm_pkg::t_out_word o_result
);
    import twhm_pkg::*;

    t_in_word           r_in;
    logic [CntW-1:0]    r_count;
    logic [23:0]        r_energy [MaxHits];
    logic [MaxHits-1:0][31:0] r_time;
    t_hit_body          r_body   [MaxHits];
    logic               r_hit;
    logic [IdxW-1:0]    r_pick;
    logic [23:0]        r_pick_e;
    t_hit_body          r_pick_b;
    logic               r_strobe;
    t_out_word          r_res;

    // Per-entry window compare of the incoming word
    logic [MaxHits-1:0] match;
    logic [MaxHits-1:0][32:0] diffs;
    always_comb begin
        for (int k = 0; k < MaxHits; k++) begin
            diffs[k] = (i_word.hit_time >= r_time[k]) ? {1'b0, i_word.hit_time - r_time[k]}
                                                      : {1'b0, r_time[k] - i_word.hit_time};
            match[k] = (CntW'(k) < r_count) && (diffs[k] <= {17'd0, i_window});
        end
    end

    // Priority pick of lowest matching entry
    logic            any_match;
    logic [IdxW-1:0] pick;
    always_comb begin
        any_match = 1'b0;
        pick      = '0;
        for (int k = MaxHits - 1; k >= 0; k--) begin
            if (match[k]) begin
                any_match = 1'b1;
                pick      = IdxW'(k);
            end
        end
    end

    // Update values from the registered pick and the entry read at capture
    logic [24:0] esum;
    logic [23:0] esat;
    logic        earlier;
    logic        full;
    logic [IdxW-1:0] new_idx;
    t_hit_body   in_body;
    t_hit_body   pick_body;
    always_comb begin
        esum     = {1'b0, r_pick_e} + {1'b0, r_in.energy_deposit};
        esat     = esum[24] ? 24'hFFFFFF : esum[23:0];
        earlier  = r_in.hit_time < r_pick_b.tm;
        full     = r_count >= CntW'(MaxHits);
        new_idx  = r_count[IdxW-1:0];
        in_body  = '{r_in.hit_time, r_in.pos_x, r_in.pos_y, r_in.pos_z,
                     r_in.mom_x, r_in.mom_y, r_in.mom_z, r_in.track_id};
        pick_body = earlier ? in_body : r_pick_b;
    end

    // Input capture with pick and table read, then table update
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in     <= i_word;
            r_hit    <= any_match;
            r_pick   <= pick;
            r_pick_e <= r_energy[pick];
            r_pick_b <= r_body[pick];
        end
        if (i_cmd.do_update) begin
            if (r_hit) begin
                r_energy[r_pick] <= esat;
                if (earlier) begin
                    r_body[r_pick] <= in_body;
                    r_time[r_pick] <= r_in.hit_time;
                end
            end else if (!full) begin
                r_energy[new_idx] <= r_in.energy_deposit;
                r_body[new_idx]   <= in_body;
                r_time[new_idx]   <= r_in.hit_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.do_update && !r_hit && !full) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.rd_req && i_cmd.rd_last) begin
            r_count <= '0;
        end
    end

    function automatic t_out_word hit_word(logic [2:0] kind, logic [IdxW-1:0] idx,
                                           logic [23:0] e, t_hit_body b, logic lst);
        t_out_word w;
        w = '{kind, idx, e, b.tm, b.px, b.py, b.pz, b.mx, b.my, b.mz, b.trk, lst};
        return w;
    endfunction

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else r_strobe <= i_cmd.emit_blank || i_cmd.do_update || i_cmd.rd_req;
        if (i_cmd.emit_blank) begin
            r_res <= '0;
            r_res.record_kind <= i_cmd.blank_kind;
            r_res.last <= 1'b1;
        end else if (i_cmd.do_update) begin
            if (r_hit)
                r_res <= hit_word(KIND_MERGED, r_pick, esat, pick_body, 1'b1);
            else if (!full)
                r_res <= hit_word(KIND_NEW, new_idx, r_in.energy_deposit, in_body, 1'b1);
            else begin
                r_res <= '0;
                r_res.record_kind <= KIND_DROPPED;
                r_res.last <= 1'b1;
            end
        end else if (i_cmd.rd_req) begin
            r_res <= hit_word(KIND_READOUT, i_cmd.rd_idx, r_energy[i_cmd.rd_idx],
                              r_body[i_cmd.rd_idx], i_cmd.rd_last);
        end
    end

    assign o_stat   = '{r_in.operation == OP_EOE, r_in.energy_deposit == 24'd0};
    assign o_count  = r_count;
    assign o_strobe = r_strobe;
    assign o_result = r_res;
endmodule

// File: hdl/twhm_ctrl.sv
// Controller: sequences capture, update or blank result, and the readout run.
// Depends on twhm_pkg.
module twhm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  twhm_pkg::t_dp_stat i_stat,
    input  logic [twhm_pkg::CntW-1:0] i_count,
    output logic               o_busy,
    output twhm_pkg::t_ctl_cmd o_cmd
);
    import twhm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [IdxW-1:0] r_idx, n_idx;
    logic            accept;
    logic            rd_last;

    assign accept  = i_start && (r_state == S_IDLE);
    assign rd_last = ({1'b0, r_idx} + 1'b1) == i_count;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.load_in = accept;
        o_cmd.rd_idx  = r_idx;
        o_cmd.rd_last = rd_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_idx = '0;
                if (i_stat.is_eoe) begin
                    if (i_count == '0) begin
                        o_cmd.emit_blank = 1'b1;
                        o_cmd.blank_kind = KIND_EMPTY;
                        n_state = S_WAIT;
                    end else begin
                        n_state = S_READ;
                    end
                end else if (i_stat.zero_e) begin
                    o_cmd.emit_blank = 1'b1;
                    o_cmd.blank_kind = KIND_SKIPPED;
                    n_state = S_WAIT;
                end else begin
                    o_cmd.do_update = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_READ: begin
                o_cmd.rd_req = 1'b1;
                n_idx = r_idx + 1'b1;
                if (rd_last) n_state = S_WAIT;
            end
            S_WAIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// File: hdl/time_window_hit_merger_core.sv
// Top level of the time window hit merger: controller plus datapath.
// Depends on twhm_pkg, twhm_ctrl, twhm_datapath.
//
// Give a word with start while busy is low. The word is compared against the
// stored hits as it is taken; a deposit step's result is computed from the
// captured word and pick registers and then registered with o_strobe. An end
// of event yields one result per stored hit, one a cycle, with last set on the
// final one (or one empty-event word). The receiver cannot stall: each result
// must be taken in its strobe cycle. The next word is taken only after the last
// result of the previous one, once the controller has passed its wait state and
// returned to idle.
// Write merge_window only while idle.
module time_window_hit_merger_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  twhm_pkg::t_in_word  i_word,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data,
    output logic                o_strobe,
    output twhm_pkg::t_out_word o_result
);
    import twhm_pkg::*;

    logic [15:0]     r_window;
    t_ctl_cmd        cmd;
    t_dp_stat        stat;
    logic [CntW-1:0] count;

    // Merge window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_window <= 16'd100;
        else if (i_cfg_we) r_window <= i_cfg_data;
    end

    twhm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_stat(stat), .i_count(count),
        .o_busy(busy), .o_cmd(cmd)
    );

    twhm_datapath u_dp (
        .i_clk, .i_rst_n, .i_window(r_window), .i_word, .i_cmd(cmd),
        .o_stat(stat), .o_count(count), .o_strobe, .o_result
    );
endmodule

// File: tb/time_window_hit_merger_core_tb.sv
// Testbench for time_window_hit_merger_core: drives deposit steps and end of
// event words, predicts every result word and checks it. Depends on twhm_pkg.
`timescale 1ns / 100ps

module time_window_hit_merger_core_tb;
    import twhm_pkg::*;

    // Hit table predictor and store of expected result words
    class hit_merge_board;
        logic [15:0] window;
        int          n_hits;
        logic [23:0] e_tab [MaxHits];
        t_hit_body   b_tab [MaxHits];
        t_out_word   pending [$];
        int          n_errors;

        function new();
            window   = 16'd100;
            n_hits   = 0;
            n_errors = 0;
        endfunction

        function t_out_word hit_word(logic [2:0] kind, int idx, logic lst);
            t_out_word r;
            r.record_kind = kind;
            r.entry_index = idx[5:0];
            r.out_energy  = e_tab[idx];
            r.out_time    = b_tab[idx].tm;
            r.out_pos_x   = b_tab[idx].px;
            r.out_pos_y   = b_tab[idx].py;
            r.out_pos_z   = b_tab[idx].pz;
            r.out_mom_x   = b_tab[idx].mx;
            r.out_mom_y   = b_tab[idx].my;
            r.out_mom_z   = b_tab[idx].mz;
            r.out_track   = b_tab[idx].trk;
            r.last        = lst;
            return r;
        endfunction

        function t_out_word blank_word(logic [2:0] kind);
            t_out_word r;
            r = '0;
            r.record_kind = kind;
            r.last = 1'b1;
            return r;
        endfunction

        function t_hit_body body_of(t_in_word w);
            t_hit_body b;
            b.tm = w.hit_time; b.px = w.pos_x; b.py = w.pos_y; b.pz = w.pos_z;
            b.mx = w.mom_x; b.my = w.mom_y; b.mz = w.mom_z; b.trk = w.track_id;
            return b;
        endfunction

        // Note an accepted input word and queue its results
        function void note_word(t_in_word w);
            logic [31:0] diff;
            logic [24:0] sum;
            if (w.operation == OP_EOE) begin
                if (n_hits == 0) pending.push_back(blank_word(KIND_EMPTY));
                for (int i = 0; i < n_hits; i++)
                    pending.push_back(hit_word(KIND_READOUT, i, i == n_hits - 1));
                n_hits = 0;
                return;
            end
            if (w.energy_deposit == 0) begin
                pending.push_back(blank_word(KIND_SKIPPED));
                return;
            end
            for (int i = 0; i < n_hits; i++) begin
                diff = (w.hit_time >= b_tab[i].tm) ? w.hit_time - b_tab[i].tm
                                                    : b_tab[i].tm - w.hit_time;
                if (diff <= {16'd0, window}) begin
                    sum = {1'b0, e_tab[i]} + {1'b0, w.energy_deposit};
                    e_tab[i] = sum[24] ? 24'hFFFFFF : sum[23:0];
                    if (w.hit_time < b_tab[i].tm) b_tab[i] = body_of(w);
                    pending.push_back(hit_word(KIND_MERGED, i, 1'b1));
                    return;
                end
            end
            if (n_hits >= MaxHits) begin
                pending.push_back(blank_word(KIND_DROPPED));
                return;
            end
            e_tab[n_hits] = w.energy_deposit;
            b_tab[n_hits] = body_of(w);
            pending.push_back(hit_word(KIND_NEW, n_hits, 1'b1));
            n_hits++;
        endfunction

        // Compare one result word against the oldest expectation
        function void check_word(t_out_word a);
            t_out_word x;
            if (pending.size() == 0) begin
                $error("unexpected result word kind %0d", a.record_kind);
                n_errors++;
                return;
            end
            x = pending.pop_front();
            if (a.record_kind !== x.record_kind) begin
                $error("record_kind exp %0d got %0d", x.record_kind, a.record_kind); n_errors++; end
            if (a.entry_index !== x.entry_index) begin
                $error("entry_index exp %0d got %0d", x.entry_index, a.entry_index); n_errors++; end
            if (a.out_energy !== x.out_energy) begin
                $error("out_energy exp %h got %h", x.out_energy, a.out_energy); n_errors++; end
            if (a.out_time !== x.out_time) begin
                $error("out_time exp %h got %h", x.out_time, a.out_time); n_errors++; end
            if (a.out_pos_x !== x.out_pos_x) begin
                $error("out_pos_x exp %h got %h", x.out_pos_x, a.out_pos_x); n_errors++; end
            if (a.out_pos_y !== x.out_pos_y) begin
                $error("out_pos_y exp %h got %h", x.out_pos_y, a.out_pos_y); n_errors++; end
            if (a.out_pos_z !== x.out_pos_z) begin
                $error("out_pos_z exp %h got %h", x.out_pos_z, a.out_pos_z); n_errors++; end
            if (a.out_mom_x !== x.out_mom_x) begin
                $error("out_mom_x exp %h got %h", x.out_mom_x, a.out_mom_x); n_errors++; end
            if (a.out_mom_y !== x.out_mom_y) begin
                $error("out_mom_y exp %h got %h", x.out_mom_y, a.out_mom_y); n_errors++; end
            if (a.out_mom_z !== x.out_mom_z) begin
                $error("out_mom_z exp %h got %h", x.out_mom_z, a.out_mom_z); n_errors++; end
            if (a.out_track !== x.out_track) begin
                $error("out_track exp %h got %h", x.out_track, a.out_track); n_errors++; end
            if (a.last !== x.last) begin
                $error("last exp %0d got %0d", x.last, a.last); n_errors++; end
        endfunction
    endclass

    localparam int StallLimit = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_word    i_word;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        o_strobe;
    t_out_word   o_result;

    hit_merge_board board;
    int          idle_cycles;
    bit          no_gaps;
    logic [31:0] base_time;

    time_window_hit_merger_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_word     (i_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result checking and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) board.check_word(o_result);
            if (o_strobe || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > StallLimit) begin
                $display("FAIL time_window_hit_merger_core");
                $finish;
            end
        end
    end

    // Hand one word to the block and wait until it is taken; start stays high
    // while busy until the next gap or the caller drops it
    task automatic send_word(t_in_word w);
        if (!no_gaps) begin
            while ($urandom_range(99) < 21) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        board.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic write_window(logic [15:0] v);
        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.window = v;
    endtask

    function automatic t_in_word rand_step(logic [31:0] t, logic [23:0] e);
        t_in_word w;
        w.operation      = OP_STEP;
        w.energy_deposit = e;
        w.hit_time       = t;
        w.pos_x          = 24'($urandom);
        w.pos_y          = 24'($urandom);
        w.pos_z          = 24'($urandom);
        w.mom_x          = $urandom;
        w.mom_y          = $urandom;
        w.mom_z          = $urandom;
        w.track_id       = 20'($urandom);
        return w;
    endfunction

    function automatic t_in_word eoe_word();
        t_in_word w;
        w = rand_step($urandom, 24'($urandom));
        w.operation = OP_EOE;
        return w;
    endfunction

    initial begin
        t_in_word w;
        int       n_ev;
        board       = new();
        idle_cycles = 0;
        no_gaps     = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_word      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty event, zero energy, extremes, merge rules
        send_word(eoe_word());
        send_word(rand_step(32'd500, 24'd0));
        w = rand_step(32'hFFFFFFFF, 24'hFFFFFF);
        w.pos_x = 24'sh7FFFFF; w.mom_x = 32'sh80000000; w.track_id = 20'hFFFFF;
        send_word(w);
        send_word(rand_step(32'hFFFFFF9B, 24'd5));   // window edge, earlier: saturate
        send_word(rand_step(32'd1000, 24'd1));
        send_word(rand_step(32'd1000, 24'd7));       // equal time, energy only
        send_word(rand_step(32'd1101, 24'd3));       // just outside: new hit
        send_word(rand_step(32'd1050, 24'd2));       // matches both, lowest wins
        w = rand_step(32'd0, 24'd9);
        w.pos_y = 24'sh800000; w.mom_z = 32'sh7FFFFFFF; w.track_id = '0;
        send_word(w);
        send_word(eoe_word());

        // Full table, then drops; window zero
        write_window(16'd0);
        for (int i = 0; i < MaxHits + 3; i++)
            send_word(rand_step(32'(i * 10), 24'($urandom_range(1, 50))));
        send_word(rand_step(32'd5, 24'd4));
        send_word(eoe_word());

        // Random events under several window settings
        no_gaps = 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) no_gaps = 1'b0;
            case (ph)
                0: write_window(16'hFFFF);
                1: write_window(16'd100);
                2: write_window(16'($urandom));
                default: write_window(16'd0);
            endcase
            n_ev = 0;
            while (n_ev < 30) begin
                base_time = $urandom;
                for (int k = $urandom_range(0, 12); k > 0; k--) begin
                    if ($urandom_range(9) == 0)
                        send_word(rand_step($urandom,
                                            24'($urandom_range(1) ? 0 : $urandom)));
                    else
                        send_word(rand_step(base_time + $urandom_range(0, 400),
                                            $urandom_range(3) == 0 ? 24'hFFFFF0 :
                                            24'($urandom_range(1, 1000))));
                    n_ev++;
                end
                send_word(eoe_word());
                n_ev++;
            end
        end

        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (board.n_errors == 0)
            $display("PASS time_window_hit_merger_core");
        else
            $display("FAIL time_window_hit_merger_core");
        $finish;
    end

endmodule

// File: filelist.f
hdl/twhm_pkg.sv
hdl/twhm_datapath.sv
hdl/twhm_ctrl.sv
hdl/time_window_hit_merger_core.sv
tb/time_window_hit_merger_core_tb.sv
